/* hw/rtl/rxyz_pkg.sv */
// ----------------------------------------------------------------------------
// rxyz_pkg
// Shared constants, coefficient rounding and types of the RGB to XYZ
// chromaticity converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rxyz_pkg;

   // field widths
   localparam int SampleW  = 16;
   localparam int TristimW = 32;
   localparam int ChromaW  = 16;
   localparam int SumW     = 34;

   // default fraction widths
   localparam int CoefFracBits   = 16;
   localparam int ChromaFracBits = 16;

   // register indexes
   localparam int RegSampleDepth = 0;
   localparam int RegCount       = 1;

   // matrix in units of 1e-7, row major
   localparam longint unsigned DecScale = 64'd10000000;
   localparam longint unsigned DecHalf  = 64'd5000000;
   localparam longint unsigned MatDec [9] = '{
      64'd4887180, 64'd3106803, 64'd2006017,
      64'd1762044, 64'd8129847, 64'd108109,
      64'd0,       64'd102048,  64'd9897952
   };

   // round a decimal coefficient to nearest in Q0.frac
   function automatic longint unsigned qcoef(input longint unsigned n,
                                             input int unsigned frac);
      return ((n << frac) + DecHalf) / DecScale;
   endfunction

   // side data carried alongside the divider
   typedef struct packed {
      logic [2:0][TristimW-1:0] t;
      logic                     zero;
      logic                     last;
   } side_type;

endpackage

`default_nettype wire

/* hw/rtl/rxyz_if.sv */
// ----------------------------------------------------------------------------
// rxyz_if
// Pixel request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface rxyz_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] red;
   logic [15:0] green;
   logic [15:0] blue;
   logic        last_pixel;

   modport source (output valid, red, green, blue, last_pixel, input ready);
   modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface rxyz_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] tristim_x;
   logic [31:0] tristim_y;
   logic [31:0] tristim_z;
   logic [15:0] chroma_x;
   logic [15:0] chroma_y;
   logic [15:0] chroma_z;
   logic        last_out;

   modport source (output valid, tristim_x, tristim_y, tristim_z,
                   chroma_x, chroma_y, chroma_z, last_out, input ready);
   modport sink   (input valid, tristim_x, tristim_y, tristim_z,
                   chroma_x, chroma_y, chroma_z, last_out, output ready);
endinterface

`default_nettype wire

/* hw/rtl/rxyz_chroma_div.sv */
// ----------------------------------------------------------------------------
// rxyz_chroma_div
// Three-lane restoring divider, one quotient bit per register stage.
// Gives (part << FracBits) / sum for parts not above sum.
// ----------------------------------------------------------------------------
`default_nettype none

module rxyz_chroma_div #(
   parameter int FracBits = rxyz_pkg::ChromaFracBits
) (
   input  wire logic                                     clock,
   input  wire logic [FracBits:0]                        step_en,
   input  wire logic [2:0][rxyz_pkg::TristimW-1:0]       part,
   input  wire logic [rxyz_pkg::SumW-1:0]                sum,
   output logic      [2:0][FracBits:0]                   quot
);

   localparam int Steps = FracBits + 1;
   localparam int SW    = rxyz_pkg::SumW;

   logic [SW-1:0]            sum_ff [Steps];
   logic [2:0][SW-1:0]       rem_ff [Steps];
   logic [2:0][FracBits:0]   quo_ff [Steps];

   for (genvar j = 0; j < Steps; j++) begin : g_step
      logic [SW-1:0]          sum_prev;
      logic [2:0][SW-1:0]     rem_in;
      logic [2:0][FracBits:0] quo_in;
      logic [2:0][SW:0]       cand;
      logic [2:0][SW:0]       diff;
      logic [2:0]             ge;

      if (j == 0) begin : g_first
         assign sum_prev = sum;
      end else begin : g_next
         assign sum_prev = sum_ff[j-1];
      end

      // trial subtract per lane
      always_comb begin
         for (int l = 0; l < 3; l++) begin
            if (j == 0) begin
               cand[l] = (SW+1)'(part[l]);
            end else begin
               cand[l] = {rem_ff[j > 0 ? j-1 : 0][l], 1'b0};
            end
            diff[l]   = cand[l] - {1'b0, sum_prev};
            ge[l]     = cand[l] >= {1'b0, sum_prev};
            rem_in[l] = ge[l] ? diff[l][SW-1:0] : cand[l][SW-1:0];
            if (j == 0) begin
               quo_in[l] = (FracBits+1)'(ge[l]);
            end else begin
               quo_in[l] = {quo_ff[j > 0 ? j-1 : 0][l][FracBits-1:0], ge[l]};
            end
         end
      end

      // advance the stage
      always_ff @(posedge clock) begin
         if (step_en[j]) begin
            sum_ff[j] <= sum_prev;
            rem_ff[j] <= rem_in;
            quo_ff[j] <= quo_in;
         end
      end
   end

   assign quot = quo_ff[Steps-1];

endmodule

`default_nettype wire

/* hw/rtl/rgb_to_xyz_chromaticity.sv */
// ----------------------------------------------------------------------------
// rgb_to_xyz_chromaticity
// RGB pixel to CIE XYZ (Q16.16) and xyz chromaticity (Q0.16) converter.
// ----------------------------------------------------------------------------
//  port      dir   handshake            payload
//  req_chan  in    valid/ready          red, green, blue, last_pixel
//  rsp_chan  out   valid/ready          tristim_x/y/z, chroma_x/y/z, last_out
//  psel...   in    APB write/read       sample_depth at address 0
//
//  One pixel per clock unless rsp_chan stalls. Stages in order: multiply,
//  row add and saturate, sum, one divider stage per quotient bit, output.
//  Each stage holds only while the one after it is full and stalled, so
//  bubbles close up. Synchronous reset clears valid bits and sample_depth.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_xyz_chromaticity #(
   parameter int COEF_FRAC_BITS   = rxyz_pkg::CoefFracBits,
   parameter int CHROMA_FRAC_BITS = rxyz_pkg::ChromaFracBits
) (
   input  wire logic        clock,
   input  wire logic        reset,
   rxyz_req_if.sink         req_chan,
   rxyz_rsp_if.source       rsp_chan,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic      [31:0] prdata,
   output logic             pready
);

   localparam int C     = COEF_FRAC_BITS;
   localparam int F     = CHROMA_FRAC_BITS;
   localparam int PW    = C + 16;
   localparam int AW    = C + 18;
   localparam int TW    = rxyz_pkg::TristimW;
   localparam int SW    = rxyz_pkg::SumW;
   localparam int Steps = F + 1;
   localparam int N     = F + 5;
   localparam int CapInt = (F > 16) ? 65535 : ((1 << F) - 1);
   localparam logic [F:0] Cap = (F+1)'(CapInt);

   // configuration register
   logic depth_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= 1'b0;
      end else if (psel && penable && pwrite && 32'(paddr[2]) == rxyz_pkg::RegSampleDepth) begin
         depth_ff <= pwdata[0];
      end
   end

   always_comb begin
      prdata = '0;
      if (32'(paddr[2]) == rxyz_pkg::RegSampleDepth) begin
         prdata = {31'b0, depth_ff};
      end
   end

   // stage valid bits and advance chain
   logic [N-1:0] v_ff;
   logic [N-1:0] v_in;
   logic [N-1:0] adv;

   always_comb begin
      adv[N-1] = !v_ff[N-1] || rsp_chan.ready;
      for (int k = N - 2; k >= 0; k--) begin
         adv[k] = !v_ff[k] || adv[k+1];
      end
      v_in[0] = req_chan.valid;
      for (int k = 1; k < N; k++) begin
         v_in[k] = v_ff[k-1];
      end
   end

   assign req_chan.ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (adv[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   // stage 0: mask samples, nine products
   logic [2:0][15:0]  smp;
   logic [PW-1:0]     prod_ff [9];
   logic [PW-1:0]     prod_in [9];
   logic              last0_ff;

   always_comb begin
      smp[0] = depth_ff ? req_chan.red   : {8'b0, req_chan.red[7:0]};
      smp[1] = depth_ff ? req_chan.green : {8'b0, req_chan.green[7:0]};
      smp[2] = depth_ff ? req_chan.blue  : {8'b0, req_chan.blue[7:0]};
   end

   for (genvar k = 0; k < 9; k++) begin : g_mul
      localparam longint unsigned Cq = rxyz_pkg::qcoef(rxyz_pkg::MatDec[k], C);
      localparam logic [C-1:0] Coef = C'(Cq);
      assign prod_in[k] = {16'b0, Coef} * {{C{1'b0}}, smp[k % 3]};
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int k = 0; k < 9; k++) begin
            prod_ff[k] <= prod_in[k];
         end
         last0_ff <= req_chan.last_pixel;
      end
   end

   // stage 1: row sums, scale to Q16.16, saturate
   logic [2:0][TW-1:0] t_ff;
   logic [2:0][TW-1:0] t_in;
   logic               last1_ff;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         logic [AW-1:0]    acc;
         logic [AW+15:0]   ext;
         logic [33:0]      q16;
         acc = AW'(prod_ff[3*r]) + AW'(prod_ff[3*r+1]) + AW'(prod_ff[3*r+2]);
         ext = {acc, 16'b0} >> C;
         q16 = ext[33:0];
         t_in[r] = (|q16[33:32]) ? {TW{1'b1}} : q16[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         t_ff     <= t_in;
         last1_ff <= last0_ff;
      end
   end

   // stage 2: total and zero flag; side data then follows the divider
   rxyz_pkg::side_type side_ff [Steps+1];
   logic [SW-1:0]      sum_ff;
   logic [SW-1:0]      sum_in;

   assign sum_in = SW'(t_ff[0]) + SW'(t_ff[1]) + SW'(t_ff[2]);

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         sum_ff         <= sum_in;
         side_ff[0].t    <= t_ff;
         side_ff[0].zero <= (sum_in == '0);
         side_ff[0].last <= last1_ff;
      end
      for (int j = 0; j < Steps; j++) begin
         if (adv[3+j]) begin
            side_ff[j+1] <= side_ff[j];
         end
      end
   end

   // divider stages
   logic [2:0][F:0] quot;

   rxyz_chroma_div #(
      .FracBits (F)
   ) u_div (
      .clock   (clock),
      .step_en (adv[3 +: Steps]),
      .part    (side_ff[0].t),
      .sum     (sum_ff),
      .quot    (quot)
   );

   // output stage: cap, zero sum, register
   logic [2:0][15:0]   chroma_ff;
   logic [2:0][15:0]   chroma_in;
   logic [2:0][TW-1:0] tout_ff;
   logic               last_ff;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         logic [F:0] capped;
         capped = (quot[l] >= Cap) ? Cap : quot[l];
         chroma_in[l] = side_ff[Steps].zero ? 16'b0 : 16'(capped);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[N-1]) begin
         chroma_ff <= chroma_in;
         tout_ff   <= side_ff[Steps].t;
         last_ff   <= side_ff[Steps].last;
      end
   end

   assign rsp_chan.valid     = v_ff[N-1];
   assign rsp_chan.tristim_x = tout_ff[0];
   assign rsp_chan.tristim_y = tout_ff[1];
   assign rsp_chan.tristim_z = tout_ff[2];
   assign rsp_chan.chroma_x  = chroma_ff[0];
   assign rsp_chan.chroma_y  = chroma_ff[1];
   assign rsp_chan.chroma_z  = chroma_ff[2];
   assign rsp_chan.last_out  = last_ff;

`ifndef NO_ASSERTIONS
   // an accepted item occupies the first stage next cycle
   a_enter: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> v_ff[0])
      else $error("accepted item not held in first stage");

   // a stalled result stays put
   a_hold: assert property (@(posedge clock) disable iff (reset)
      v_ff[N-1] && !rsp_chan.ready |=> v_ff[N-1] && $stable(chroma_ff))
      else $error("stalled result lost or changed");

   // all-zero tristimulus gives zero chromaticity
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.tristim_x == '0 && rsp_chan.tristim_y == '0
      && rsp_chan.tristim_z == '0 |-> chroma_ff == '0)
      else $error("zero sum gave non-zero chromaticity");
`endif

endmodule

`default_nettype wire

/* verif/rxyz_checker.sv */
// ----------------------------------------------------------------------------
// rxyz_checker
// Watches the pixel and result channels, predicts X, Y, Z and the xyz
// chromaticities of every accepted pixel and compares them in order.
// ----------------------------------------------------------------------------
module rxyz_checker (
   input  logic        clock,
   input  logic        reset,
   rxyz_req_if         req_chan,
   rxyz_rsp_if         rsp_chan,
   input  logic        sample_depth,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] tx;
      logic [31:0] ty;
      logic [31:0] tz;
      logic [15:0] cx;
      logic [15:0] cy;
      logic [15:0] cz;
      logic        last;
   } xyz_result_type;

   xyz_result_type expected_xyz[$];
   longint unsigned coef[9];

   // round the matrix to Q0.16 once
   initial begin
      for (int i = 0; i < 9; i++)
         coef[i] = ((rxyz_pkg::MatDec[i] << 16) + 64'd5000000) / 64'd10000000;
   end

   function automatic logic [15:0] chroma_ratio(longint unsigned part,
                                                longint unsigned sum);
      longint unsigned q;
      if (sum == 0) return '0;
      q = (part << 16) / sum;
      return (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
   endfunction

   function automatic xyz_result_type convert_pixel(logic [15:0] r, logic [15:0] g,
                                                    logic [15:0] b, logic last,
                                                    logic depth);
      longint unsigned s[3];
      longint unsigned t[3];
      longint unsigned acc;
      longint unsigned sum;
      xyz_result_type res;
      s[0] = depth ? r : r[7:0];
      s[1] = depth ? g : g[7:0];
      s[2] = depth ? b : b[7:0];
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         for (int j = 0; j < 3; j++) acc += coef[3*i+j] * s[j];
         t[i] = (acc > 64'hFFFFFFFF) ? 64'hFFFFFFFF : acc;
      end
      sum = t[0] + t[1] + t[2];
      res.tx = t[0]; res.ty = t[1]; res.tz = t[2];
      res.cx = chroma_ratio(t[0], sum);
      res.cy = chroma_ratio(t[1], sum);
      res.cz = chroma_ratio(t[2], sum);
      res.last = last;
      return res;
   endfunction

   assign pending = expected_xyz.size();

   initial fail_count = 0;

   // predict on input items, compare on result items
   always @(posedge clock) begin
      xyz_result_type got;
      xyz_result_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            expected_xyz.push_back(convert_pixel(req_chan.red, req_chan.green,
                                                 req_chan.blue, req_chan.last_pixel,
                                                 sample_depth));
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.tristim_x, rsp_chan.tristim_y, rsp_chan.tristim_z,
                    rsp_chan.chroma_x, rsp_chan.chroma_y, rsp_chan.chroma_z,
                    rsp_chan.last_out};
            if (expected_xyz.size() == 0) begin
               $display("%0t: unexpected result item %h", $time, got);
               fail_count++;
            end else begin
               want = expected_xyz.pop_front();
               if (got.tx !== want.tx) begin
                  $display("%0t: X exp %h got %h", $time, want.tx, got.tx); fail_count++;
               end
               if (got.ty !== want.ty) begin
                  $display("%0t: Y exp %h got %h", $time, want.ty, got.ty); fail_count++;
               end
               if (got.tz !== want.tz) begin
                  $display("%0t: Z exp %h got %h", $time, want.tz, got.tz); fail_count++;
               end
               if (got.cx !== want.cx) begin
                  $display("%0t: x exp %h got %h", $time, want.cx, got.cx); fail_count++;
               end
               if (got.cy !== want.cy) begin
                  $display("%0t: y exp %h got %h", $time, want.cy, got.cy); fail_count++;
               end
               if (got.cz !== want.cz) begin
                  $display("%0t: z exp %h got %h", $time, want.cz, got.cz); fail_count++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last exp %b got %b", $time, want.last, got.last);
                  fail_count++;
               end
            end
         end
      end
   end
endmodule

/* verif/rgb_to_xyz_chromaticity_test.sv */
// ----------------------------------------------------------------------------
// rgb_to_xyz_chromaticity_test
// Drives directed and random pixels in both sample depths with random gaps
// and result back-pressure; the checker predicts and compares every item.
// ----------------------------------------------------------------------------
module rgb_to_xyz_chromaticity_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        psel = 0, penable = 0, pwrite = 0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;
   logic        depth_shadow = 0;
   logic        stall_hold = 0;
   int          fail_count;
   int          pending;

   rxyz_req_if req_chan ();
   rxyz_rsp_if rsp_chan ();

   rgb_to_xyz_chromaticity dut (
      .clock, .reset, .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source),
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   rxyz_checker checker_i (
      .clock, .reset, .req_chan, .rsp_chan, .sample_depth(depth_shadow),
      .fail_count, .pending
   );

   always #4 clock = ~clock;

   initial begin
      req_chan.valid = 0; req_chan.red = 0; req_chan.green = 0;
      req_chan.blue = 0; req_chan.last_pixel = 0;
      rsp_chan.ready = 0;
   end

   // give a random gap length, mostly short
   function automatic int gap_len();
      int p = $urandom_range(0, 99);
      if (p < 50) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // receiver: random stalls, plus a long hold-off when asked
   always @(posedge clock) begin
      if (reset || stall_hold) rsp_chan.ready <= 0;
      else rsp_chan.ready <= (gap_len() == 0) || ($urandom_range(0, 3) == 0);
   end

   task automatic csr_write(logic [2:0] addr, logic [31:0] data);
      @(posedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      if (addr == 3'(4 * rxyz_pkg::RegSampleDepth)) depth_shadow = data[0];
   endtask

   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   // drop valid only across a gap, so back-to-back items see one update
   task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                             logic last, int gap);
      if (gap > 0) begin
         req_chan.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1; req_chan.red <= r; req_chan.green <= g;
      req_chan.blue <= b; req_chan.last_pixel <= last;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic directed_set();
      send_pixel(16'h0000, 16'h0000, 16'h0000, 0, 0);
      send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0);
      send_pixel(16'hFF00, 16'hFF00, 16'hFF00, 0, 0);
      send_pixel(16'h00FF, 16'h0000, 16'h0000, 0, 0);
      send_pixel(16'h0000, 16'h00FF, 16'h0000, 0, 0);
      send_pixel(16'h0000, 16'h0000, 16'h00FF, 1, 0);
      send_pixel(16'hFFFF, 16'h0000, 16'h0000, 0, 1);
      send_pixel(16'h0000, 16'hFFFF, 16'h0000, 0, 0);
      send_pixel(16'h0000, 16'h0000, 16'hFFFF, 0, 0);
      send_pixel(16'h0001, 16'h0000, 16'h0000, 0, 0);
      send_pixel(16'h0000, 16'h0000, 16'h0001, 1, 0);
      req_chan.valid <= 0;
   endtask

   task automatic random_burst(int n);
      logic [15:0] r, g, b;
      for (int i = 0; i < n; i++) begin
         r = 16'($urandom); g = 16'($urandom); b = 16'($urandom);
         // bias some pixels towards one channel or near-zero values
         case ($urandom_range(0, 7))
            0: begin g = 0; b = 0; end
            1: begin r = 0; g = 0; end
            2: begin
               r = 16'($urandom_range(0, 3)); g = 16'($urandom_range(0, 3)); b = 0;
            end
            default: ;
         endcase
         if (i > n / 2 && i < n / 2 + 40) send_pixel(r, g, b, 1'($urandom), 0);
         else send_pixel(r, g, b, 1'($urandom), gap_len());
      end
      req_chan.valid <= 0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      directed_set();
      drain();
      csr_write(3'(4 * rxyz_pkg::RegSampleDepth), 32'h1);
      directed_set();
      random_burst(300);
      // hold the receiver off while items keep coming
      stall_hold <= 1;
      fork
         random_burst(60);
         begin
            repeat (200) @(posedge clock);
            stall_hold <= 0;
         end
      join
      drain();
      csr_write(3'(4 * rxyz_pkg::RegSampleDepth), 32'h0);
      random_burst(250);
      drain();
      csr_write(3'(4 * rxyz_pkg::RegSampleDepth), 32'hFFFFFFFF);
      random_burst(250);
      drain();
      if (fail_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #4ms;
      $display("Test completed with failures");
      $finish;
   end
endmodule

/* files.f */
hw/rtl/rxyz_pkg.sv
hw/rtl/rxyz_if.sv
hw/rtl/rxyz_chroma_div.sv
hw/rtl/rgb_to_xyz_chromaticity.sv
verif/rxyz_checker.sv
verif/rgb_to_xyz_chromaticity_test.sv
